@@ rtl/core/block_ownership_checker_top_macros.svh @@
// Assertion macros for the block ownership checker.
`ifndef BLOCK_OWNERSHIP_CHECKER_TOP_MACROS_SVH
`define BLOCK_OWNERSHIP_CHECKER_TOP_MACROS_SVH
`ifndef SYNTH
`define BOC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("boc assertion failed");
`define BOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("boc assertion failed");
`else
`define BOC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BOC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/boc_pkg.sv @@
// Types and constants shared by the block ownership checker.
package boc_pkg;
	localparam logic [31:0] OwnerFree       = 32'h0000_0000;
	localparam logic [31:0] OwnerUnassigned = 32'hffff_ffff;
	localparam logic [7:0]  KindAllocator   = 8'd3;

	typedef enum logic [1:0] {
		REQ_ALLOC   = 2'd0,
		REQ_FREE    = 2'd1,
		REQ_ASSIGN  = 2'd2,
		REQ_RELEASE = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		VIOL_NONE          = 3'd0,
		VIOL_DOUBLE_ALLOC  = 3'd1,
		VIOL_FREE_WHEN_FREE = 3'd2,
		VIOL_FREE_OWNED    = 3'd3,
		VIOL_ASSIGN_BAD    = 3'd4
	} viol_t;

	typedef enum logic [1:0] {
		ST_FREE       = 2'd0,
		ST_UNASSIGNED = 2'd1,
		ST_OWNED      = 2'd2
	} rec_state_t;

	typedef struct packed {
		logic [31:0] owner;
		logic [31:0] logical;
		logic [7:0]  kind;
	} rec_t;
endpackage

@@ rtl/core/boc_if.sv @@
// Request and response channel interfaces of the block ownership checker.
interface boc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] block_number;
	logic [31:0] owner_inode;
	logic [31:0] logical_block;
	logic [7:0]  block_kind;

	modport source(output valid, req_type, block_number, owner_inode, logical_block,
		block_kind, input ready);
	modport sink(input valid, req_type, block_number, owner_inode, logical_block,
		block_kind, output ready);
endinterface

interface boc_rsp_if;
	logic        valid;
	logic        ready;
	logic        in_range;
	logic [2:0]  violation_code;
	logic [1:0]  prior_state;
	logic [31:0] prior_owner;
	logic [31:0] prior_logical;
	logic [7:0]  prior_kind;
	logic [31:0] violations_seen;

	modport source(output valid, in_range, violation_code, prior_state, prior_owner,
		prior_logical, prior_kind, violations_seen, input ready);
	modport sink(input valid, in_range, violation_code, prior_state, prior_owner,
		prior_logical, prior_kind, violations_seen, output ready);
endinterface

@@ rtl/core/boc_rec_mem.sv @@
// Ownership record memory: one write port, one registered read port.
module boc_rec_mem #(
	parameter int Depth = 4096,
	parameter int AddrW = 12
) (
	input  logic                clk,
	input  logic                re,
	input  logic [AddrW-1:0]    raddr,
	output boc_pkg::rec_t       rdata,
	input  logic                we,
	input  logic [AddrW-1:0]    waddr,
	input  boc_pkg::rec_t       wdata
);
	boc_pkg::rec_t mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/core/boc_clear.sv @@
// Clearing sequencer that steps through every record address after reset.
module boc_clear #(
	parameter int Depth = 4096,
	parameter int AddrW = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	output logic             active,
	output logic [AddrW-1:0] addr
);
	localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

	logic             active_q;
	logic [AddrW-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			addr_q   <= '0;
		end else if (active_q) begin
			if (addr_q == LastAddr) begin
				active_q <= 1'b0;
			end
			addr_q <= addr_q + AddrW'(1);
		end
	end

	assign active = active_q;
	assign addr   = addr_q;
endmodule

@@ rtl/core/boc_update.sv @@
// Record update and violation check for one request.
module boc_update (
	input  boc_pkg::req_kind_t  req,
	input  boc_pkg::rec_t       prior,
	input  logic [31:0]         owner,
	input  logic [31:0]         logical,
	input  logic [7:0]          kind,
	output boc_pkg::rec_t       next_rec,
	output boc_pkg::viol_t      code,
	output boc_pkg::rec_state_t state
);
	logic is_free;
	logic is_unassigned;

	assign is_free       = (prior.owner == boc_pkg::OwnerFree);
	assign is_unassigned = (prior.owner == boc_pkg::OwnerUnassigned);

	always_comb begin
		if (is_free) begin
			state = boc_pkg::ST_FREE;
		end else if (is_unassigned) begin
			state = boc_pkg::ST_UNASSIGNED;
		end else begin
			state = boc_pkg::ST_OWNED;
		end
	end

	always_comb begin
		code     = boc_pkg::VIOL_NONE;
		next_rec = prior;
		case (req)
			boc_pkg::REQ_ALLOC: begin
				if (!is_free) begin
					code = boc_pkg::VIOL_DOUBLE_ALLOC;
				end
				next_rec.owner   = boc_pkg::OwnerUnassigned;
				next_rec.logical = '0;
				next_rec.kind    = boc_pkg::KindAllocator;
			end
			boc_pkg::REQ_FREE: begin
				if (is_free) begin
					code = boc_pkg::VIOL_FREE_WHEN_FREE;
				end else if (!is_unassigned) begin
					code = boc_pkg::VIOL_FREE_OWNED;
				end
				next_rec = '0;
			end
			boc_pkg::REQ_ASSIGN: begin
				if (!is_unassigned) begin
					code = boc_pkg::VIOL_ASSIGN_BAD;
				end
				next_rec.owner   = owner;
				next_rec.logical = logical;
				next_rec.kind    = kind;
			end
			boc_pkg::REQ_RELEASE: begin
				if (!is_free && !is_unassigned) begin
					next_rec.owner = boc_pkg::OwnerUnassigned;
				end
			end
			default: begin
				next_rec = prior;
			end
		endcase
	end
endmodule

@@ rtl/core/block_ownership_checker_top.sv @@
// Block ownership checker: keeps one ownership record per storage block.
//
// Requests arrive on req (valid/ready); each names a block and one of
// allocate, free, assign or release. One response per request leaves on rsp
// (valid/ready) with the record as it stood before the request and the
// saturating violation count after it. cfg_we/cfg_wdata set block_count;
// blocks at or above min(block_count, MAX_BLOCKS) are ignored.
//
// An accepted request passes the read stage and then the output register,
// which drives rsp.valid. The record memory is read at acceptance and
// written back as the request leaves the read stage, with the written record
// forwarded to a following request on the same block, so one request is
// taken per cycle while rsp keeps up, set by one read-modify-write per cycle.
//
// After reset the clearing sequencer zeroes every record, one per cycle, and
// req.ready stays low meanwhile. The counter and block_count clear at once.
// When rsp stalls, the response is held in the output register, one more
// request waits in the read stage, then req.ready drops.
`include "block_ownership_checker_top_macros.svh"
module block_ownership_checker_top #(
	parameter int MAX_BLOCKS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	boc_req_if.sink     req,
	boc_rsp_if.source   rsp,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata
);
	localparam int          AddrW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam logic [31:0] MaxLim = 32'(MAX_BLOCKS);

	logic [12:0]        block_count_q;
	logic [31:0]        viol_cnt_q;
	logic               clr_active;
	logic [AddrW-1:0]   clr_addr;

	logic               valid_s1;
	logic               in_range_s1;
	boc_pkg::req_kind_t type_s1;
	logic [AddrW-1:0]   addr_s1;
	logic [31:0]        owner_s1;
	logic [31:0]        logical_s1;
	logic [7:0]         kind_s1;
	logic               fwd_hit_s1;
	boc_pkg::rec_t      fwd_rec_s1;

	logic               out_valid_q;
	logic               out_in_range_q;
	logic [2:0]         out_code_q;
	logic [1:0]         out_state_q;
	logic [31:0]        out_owner_q;
	logic [31:0]        out_logical_q;
	logic [7:0]         out_kind_q;
	logic [31:0]        out_cnt_q;

	logic               accept;
	logic               advance;
	logic               in_rng;
	logic [AddrW-1:0]   req_addr;
	boc_pkg::rec_t      rd_rec;
	boc_pkg::rec_t      prior_rec;
	boc_pkg::rec_t      next_rec;
	boc_pkg::viol_t     code;
	boc_pkg::rec_state_t state;
	logic [31:0]        cnt_nxt;
	logic               mem_we;
	logic [AddrW-1:0]   mem_waddr;
	boc_pkg::rec_t      mem_wdata;

	assign req_addr = req.block_number[AddrW-1:0];
	assign in_rng   = (req.block_number < {19'd0, block_count_q}) &&
		(req.block_number < MaxLim);
	assign advance  = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !clr_active && (!valid_s1 || advance);
	assign accept   = req.valid && req.ready;

	boc_clear #(.Depth(MAX_BLOCKS), .AddrW(AddrW)) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.active (clr_active),
		.addr   (clr_addr)
	);

	assign mem_we    = clr_active || (advance && in_range_s1);
	assign mem_waddr = clr_active ? clr_addr : addr_s1;
	assign mem_wdata = clr_active ? boc_pkg::rec_t'('0) : next_rec;

	boc_rec_mem #(.Depth(MAX_BLOCKS), .AddrW(AddrW)) u_mem (
		.clk   (clk),
		.re    (accept),
		.raddr (req_addr),
		.rdata (rd_rec),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

	assign prior_rec = fwd_hit_s1 ? fwd_rec_s1 : rd_rec;

	boc_update u_update (
		.req      (type_s1),
		.prior    (prior_rec),
		.owner    (owner_s1),
		.logical  (logical_s1),
		.kind     (kind_s1),
		.next_rec (next_rec),
		.code     (code),
		.state    (state)
	);

	assign cnt_nxt = (in_range_s1 && (code != boc_pkg::VIOL_NONE) && (viol_cnt_q != '1)) ?
		viol_cnt_q + 32'd1 : viol_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= '0;
		end else if (cfg_we) begin
			block_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1   <= 1'b1;
			fwd_hit_s1 <= valid_s1 && in_range_s1 && in_rng && (req_addr == addr_s1);
		end else if (advance) begin
			valid_s1   <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_range_s1 <= in_rng;
			type_s1     <= boc_pkg::req_kind_t'(req.req_type);
			addr_s1     <= req_addr;
			owner_s1    <= req.owner_inode;
			logical_s1  <= req.logical_block;
			kind_s1     <= req.block_kind;
			fwd_rec_s1  <= next_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viol_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			viol_cnt_q  <= cnt_nxt;
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_in_range_q <= in_range_s1;
			out_code_q     <= in_range_s1 ? code : boc_pkg::VIOL_NONE;
			out_state_q    <= in_range_s1 ? state : boc_pkg::ST_FREE;
			out_owner_q    <= in_range_s1 ? prior_rec.owner : '0;
			out_logical_q  <= in_range_s1 ? prior_rec.logical : '0;
			out_kind_q     <= in_range_s1 ? prior_rec.kind : '0;
			out_cnt_q      <= cnt_nxt;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.in_range        = out_in_range_q;
	assign rsp.violation_code  = out_code_q;
	assign rsp.prior_state     = out_state_q;
	assign rsp.prior_owner     = out_owner_q;
	assign rsp.prior_logical   = out_logical_q;
	assign rsp.prior_kind      = out_kind_q;
	assign rsp.violations_seen = out_cnt_q;

	`BOC_ASSERT_IMP(a_no_req_in_clear, clk, arst_n, clr_active, !req.ready)
	`BOC_ASSERT_IMP(a_fwd_needs_s1, clk, arst_n, fwd_hit_s1, valid_s1)
	`BOC_ASSERT_NEXT(a_cnt_monotonic, clk, arst_n, 1'b1, viol_cnt_q >= $past(viol_cnt_q))
	`BOC_ASSERT_IMP(a_out_of_range_clean, clk, arst_n, rsp.valid && !rsp.in_range,
		rsp.violation_code == boc_pkg::VIOL_NONE)
endmodule
